FILE: design/lcts_pkg.sv
// ----------------------------------------------------------------------------
// lcts_pkg - shared types and constants of the LBA to CHS transfer sequencer
// Payload structs, command codes, microcode word and program ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package lcts_pkg;

    // geometry and buffer constants
    localparam int unsigned LBA_W          = 16;
    localparam int unsigned SPT_W          = 6;
    localparam int unsigned HEADS_W        = 8;
    localparam int unsigned DVS_W          = HEADS_W + 1;
    localparam int unsigned CFG_DATA_W     = 8;
    localparam logic [SPT_W-1:0] DEFAULT_SPT   = 6'd63;
    localparam logic [DVS_W-1:0] DEFAULT_HEADS = 9'd16;
    localparam logic [DVS_W-1:0] MAX_HEADS     = 9'd256;
    localparam logic [HEADS_W-1:0] RESET_HEADS = 8'd16;
    localparam logic [15:0] SEG_STEP       = 16'd32;
    localparam int unsigned LCTS_RETRY_LIMIT = 3;
    localparam int unsigned DIV_CNT_W      = $clog2(LBA_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(LBA_W - 1);

    // input item mode
    localparam logic MODE_START = 1'b0;

    typedef enum logic [1:0] {
        CMD_XFER  = 2'd0,
        CMD_RESET = 2'd1,
        CMD_DONE  = 2'd2
    } t_cmd;

    typedef enum logic {
        REG_SPT   = 1'b0,
        REG_HEADS = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_cfg_reg              index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_item;

    typedef struct packed {
        logic        mode;
        logic        is_write;
        logic [7:0]  drive_id;
        logic [15:0] start_lba;
        logic [15:0] sector_count;
        logic [15:0] seg_base;
        logic [15:0] seg_offset;
        logic        transfer_failed;
    } t_in_item;

    typedef struct packed {
        t_cmd        command;
        logic        write_dir;
        logic [15:0] cyl_sector_word;
        logic [15:0] head_drive_word;
        logic [15:0] out_segment;
        logic [15:0] out_offset;
        logic [7:0]  out_drive;
        logic        failed;
        logic        last;
    } t_out_item;

    // datapath micro-operations
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_ACCEPT,
        UOP_ADVANCE,
        UOP_SET_BUSY,
        UOP_RETRY_BUMP,
        UOP_DIV_LOAD,
        UOP_DIV_STEP,
        UOP_DIV_NEXT,
        UOP_EMIT_XFER,
        UOP_EMIT_RESET,
        UOP_EMIT_DONE_OK,
        UOP_EMIT_DONE_FAIL
    } t_uop;

    // jump conditions
    typedef enum logic [3:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_START,
        JC_IDLE,
        JC_FAILED,
        JC_MORE,
        JC_RETRY_OUT,
        JC_NO_SECTORS,
        JC_DIV_MORE
    } t_jcond;

    localparam int unsigned UPC_W = 5;
    typedef logic [UPC_W-1:0] t_upc;

    // program addresses
    localparam t_upc UPC_FETCH     = 5'd0;
    localparam t_upc UPC_IDLE_CHK  = 5'd1;
    localparam t_upc UPC_FAIL_CHK  = 5'd2;
    localparam t_upc UPC_ADVANCE   = 5'd3;
    localparam t_upc UPC_MORE_CHK  = 5'd4;
    localparam t_upc UPC_DONE_OK   = 5'd5;
    localparam t_upc UPC_RESET     = 5'd6;
    localparam t_upc UPC_RETRY     = 5'd7;
    localparam t_upc UPC_REISSUE   = 5'd8;
    localparam t_upc UPC_DONE_FAIL = 5'd9;
    localparam t_upc UPC_START     = 5'd10;
    localparam t_upc UPC_SET_BUSY  = 5'd11;
    localparam t_upc UPC_XFER      = 5'd12;
    localparam t_upc UPC_DIV1      = 5'd13;
    localparam t_upc UPC_DIV_NEXT  = 5'd14;
    localparam t_upc UPC_DIV2      = 5'd15;
    localparam t_upc UPC_EMIT_XFER = 5'd16;

    typedef struct packed {
        t_uop   op;
        logic   wait_in;
        logic   wait_out;
        t_jcond cond;
        t_upc   target;
    } t_uword;

    function automatic t_uword uw(t_uop op, logic wait_in, logic wait_out,
                                  t_jcond cond, t_upc target);
        t_uword w;
        w.op       = op;
        w.wait_in  = wait_in;
        w.wait_out = wait_out;
        w.cond     = cond;
        w.target   = target;
        return w;
    endfunction

    // control store
    function automatic t_uword lcts_urom(t_upc pc);
        t_uword w;
        unique case (pc)
            UPC_FETCH:     w = uw(UOP_ACCEPT,         1'b1, 1'b0, JC_START,      UPC_START);
            UPC_IDLE_CHK:  w = uw(UOP_NOP,            1'b0, 1'b0, JC_IDLE,       UPC_FETCH);
            UPC_FAIL_CHK:  w = uw(UOP_NOP,            1'b0, 1'b0, JC_FAILED,     UPC_RESET);
            UPC_ADVANCE:   w = uw(UOP_ADVANCE,        1'b0, 1'b0, JC_NEVER,      UPC_FETCH);
            UPC_MORE_CHK:  w = uw(UOP_NOP,            1'b0, 1'b0, JC_MORE,       UPC_XFER);
            UPC_DONE_OK:   w = uw(UOP_EMIT_DONE_OK,   1'b0, 1'b1, JC_ALWAYS,     UPC_FETCH);
            UPC_RESET:     w = uw(UOP_EMIT_RESET,     1'b0, 1'b1, JC_NEVER,      UPC_FETCH);
            UPC_RETRY:     w = uw(UOP_RETRY_BUMP,     1'b0, 1'b0, JC_RETRY_OUT,  UPC_DONE_FAIL);
            UPC_REISSUE:   w = uw(UOP_NOP,            1'b0, 1'b0, JC_ALWAYS,     UPC_XFER);
            UPC_DONE_FAIL: w = uw(UOP_EMIT_DONE_FAIL, 1'b0, 1'b1, JC_ALWAYS,     UPC_FETCH);
            UPC_START:     w = uw(UOP_NOP,            1'b0, 1'b0, JC_NO_SECTORS, UPC_DONE_OK);
            UPC_SET_BUSY:  w = uw(UOP_SET_BUSY,       1'b0, 1'b0, JC_NEVER,      UPC_FETCH);
            UPC_XFER:      w = uw(UOP_DIV_LOAD,       1'b0, 1'b0, JC_NEVER,      UPC_FETCH);
            UPC_DIV1:      w = uw(UOP_DIV_STEP,       1'b0, 1'b0, JC_DIV_MORE,   UPC_DIV1);
            UPC_DIV_NEXT:  w = uw(UOP_DIV_NEXT,       1'b0, 1'b0, JC_NEVER,      UPC_FETCH);
            UPC_DIV2:      w = uw(UOP_DIV_STEP,       1'b0, 1'b0, JC_DIV_MORE,   UPC_DIV2);
            UPC_EMIT_XFER: w = uw(UOP_EMIT_XFER,      1'b0, 1'b1, JC_ALWAYS,     UPC_FETCH);
            default:       w = uw(UOP_NOP,            1'b0, 1'b0, JC_ALWAYS,     UPC_FETCH);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: design/lcts_chan_if.sv
// ----------------------------------------------------------------------------
// lcts_chan_if - valid/ready channel
// One transaction moves when valid and ready are high at a rising edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcts_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: design/lba_to_chs_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// lba_to_chs_transfer_sequencer - LBA to CHS sector transfer sequencer
// Breaks a disk request into per-sector transfer commands with CHS addresses,
// handles completion reports, controller resets and retries.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload      Role
//  i_cfg    in   t_cfg_item   geometry register write (index, data), always ready
//  i_in     in   t_in_item    start request or completion report
//  o_out    out  t_out_item   transfer, controller reset or finished result
//
//  A sector transfer command follows a start transaction, a successful
//  completion with sectors left, or a failed one that retries: two 16-step
//  passes of the shared one-bit-per-cycle restoring divider come first.
//  A start with a zero count gives a finished result without a transfer;
//  a failed completion first gives its controller reset.
//  i_in.ready is high only in the fetch step of the microprogram.
//  Reset (synchronous, active low) returns the program counter to fetch,
//  clears busy and the result register, and sets geometry to 0 / 16 heads.
//  Emit steps wait while the result register is full and not being taken.
//
`default_nettype none

module lba_to_chs_transfer_sequencer
    import lcts_pkg::*;
#(
    parameter int unsigned RETRY_LIMIT = LCTS_RETRY_LIMIT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lcts_chan_if.sink     i_cfg,
    lcts_chan_if.sink     i_in,
    lcts_chan_if.source   o_out
);

    localparam int unsigned RTR_W = (RETRY_LIMIT > 1) ? $clog2(RETRY_LIMIT) : 1;
    localparam logic [RTR_W:0] RETRY_LIM = (RTR_W + 1)'(RETRY_LIMIT);

    // geometry registers
    logic [SPT_W-1:0]   r_spt;
    logic [HEADS_W-1:0] r_heads;

    // request state
    logic               r_busy;
    logic               r_wr;
    logic [7:0]         r_drive;
    logic [15:0]        r_lba;
    logic [15:0]        r_total;
    logic [15:0]        r_idx;
    logic [RTR_W-1:0]   r_retry;
    logic [15:0]        r_seg;
    logic [15:0]        r_off;
    logic               r_fail;

    // divider
    logic [15:0]          r_quo;
    logic [HEADS_W-1:0]   r_rem;
    logic [DVS_W-1:0]     r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SPT_W-1:0]     r_sec;

    // sequencer and result register
    t_upc      r_upc;
    t_upc      n_upc;
    t_out_item r_out;
    logic      r_out_valid;

    t_uword             w;
    logic               out_free;
    logic               hold;
    logic               fire;
    logic               jump;
    logic [SPT_W-1:0]   spt_eff;
    logic [DVS_W-1:0]   heads_eff;
    logic [DVS_W-1:0]   trial;
    logic               ge;
    logic [DVS_W-1:0]   trial_sub;

    assign w = lcts_urom(r_upc);

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spt   <= '0;
            r_heads <= RESET_HEADS;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.payload.index)
                REG_SPT:   r_spt   <= i_cfg.payload.data[SPT_W-1:0];
                REG_HEADS: r_heads <= i_cfg.payload.data[HEADS_W-1:0];
            endcase
        end
    end

    // zero sectors per track means unknown geometry; zero heads means 256
    always_comb begin
        if (r_spt == '0) begin
            spt_eff   = DEFAULT_SPT;
            heads_eff = DEFAULT_HEADS;
        end else begin
            spt_eff   = r_spt;
            heads_eff = (r_heads == '0) ? MAX_HEADS : {1'b0, r_heads};
        end
    end

    // ------------------------------------------------------------------
    // sequencer: stall, jump and next step
    // ------------------------------------------------------------------
    assign out_free = !r_out_valid || o_out.ready;
    assign hold     = (w.wait_in && !i_in.valid) || (w.wait_out && !out_free);
    assign fire     = !hold;

    always_comb begin
        unique case (w.cond)
            JC_NEVER:      jump = 1'b0;
            JC_ALWAYS:     jump = 1'b1;
            JC_START:      jump = (i_in.payload.mode == MODE_START);
            JC_IDLE:       jump = !r_busy;
            JC_FAILED:     jump = r_fail;
            JC_MORE:       jump = (r_idx < r_total);
            JC_RETRY_OUT:  jump = (({1'b0, r_retry} + 1'b1) >= RETRY_LIM);
            JC_NO_SECTORS: jump = (r_total == '0);
            JC_DIV_MORE:   jump = (r_cnt != '0);
            default:       jump = 1'b0;
        endcase
    end

    always_comb begin
        n_upc = r_upc;
        if (fire) begin
            n_upc = jump ? w.target : r_upc + 1'b1;
        end
    end

    always_comb begin
        i_in.ready  = w.wait_in;
        o_out.valid = r_out_valid;
        o_out.payload = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UPC_FETCH;
        end else begin
            r_upc <= n_upc;
        end
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    // one restoring step: remainder stays below the divisor (at most 256)
    assign trial     = {r_rem, r_quo[15]};
    assign ge        = (trial >= r_dvs);
    assign trial_sub = trial - r_dvs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_retry     <= '0;
            r_idx       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // every emit step waits on the result register
            if (fire && w.wait_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (fire) begin
                unique case (w.op)
                    UOP_NOP: begin
                    end
                    UOP_ACCEPT: begin
                        r_fail <= i_in.payload.transfer_failed;
                        if (i_in.payload.mode == MODE_START) begin
                            r_wr    <= i_in.payload.is_write;
                            r_drive <= i_in.payload.drive_id;
                            r_lba   <= i_in.payload.start_lba;
                            r_total <= i_in.payload.sector_count;
                            r_seg   <= i_in.payload.seg_base;
                            r_off   <= i_in.payload.seg_offset;
                            r_idx   <= '0;
                            r_retry <= '0;
                        end
                    end
                    UOP_ADVANCE: begin
                        r_retry <= '0;
                        r_idx   <= r_idx + 1'b1;
                        r_seg   <= r_seg + SEG_STEP;
                    end
                    UOP_SET_BUSY: begin
                        r_busy <= 1'b1;
                    end
                    UOP_RETRY_BUMP: begin
                        // out of tries: the finish step clears the count
                        if (!jump) begin
                            r_retry <= r_retry + 1'b1;
                        end
                    end
                    UOP_DIV_LOAD: begin
                        r_quo <= r_lba + r_idx;
                        r_rem <= '0;
                        r_dvs <= {{(DVS_W-SPT_W){1'b0}}, spt_eff};
                        r_cnt <= DIV_LAST;
                    end
                    UOP_DIV_STEP: begin
                        r_rem <= ge ? trial_sub[HEADS_W-1:0] : trial[HEADS_W-1:0];
                        r_quo <= {r_quo[14:0], ge};
                        r_cnt <= r_cnt - 1'b1;
                    end
                    UOP_DIV_NEXT: begin
                        // track stays in r_quo as the next dividend
                        r_sec <= r_rem[SPT_W-1:0] + 1'b1;
                        r_rem <= '0;
                        r_dvs <= heads_eff;
                        r_cnt <= DIV_LAST;
                    end
                    UOP_EMIT_XFER: begin
                        r_out <= '{command:         CMD_XFER,
                                   write_dir:       r_wr,
                                   cyl_sector_word: {r_quo[7:0], r_quo[9:8], r_sec},
                                   head_drive_word: {r_rem, r_drive},
                                   out_segment:     r_seg,
                                   out_offset:      r_off,
                                   out_drive:       8'd0,
                                   failed:          1'b0,
                                   last:            1'b1};
                    end
                    UOP_EMIT_RESET: begin
                        r_out <= '{command:         CMD_RESET,
                                   write_dir:       1'b0,
                                   cyl_sector_word: 16'd0,
                                   head_drive_word: 16'd0,
                                   out_segment:     16'd0,
                                   out_offset:      16'd0,
                                   out_drive:       r_drive,
                                   failed:          1'b0,
                                   last:            1'b0};
                    end
                    UOP_EMIT_DONE_OK: begin
                        r_busy <= 1'b0;
                        r_out  <= '{command:         CMD_DONE,
                                    write_dir:       1'b0,
                                    cyl_sector_word: 16'd0,
                                    head_drive_word: 16'd0,
                                    out_segment:     16'd0,
                                    out_offset:      16'd0,
                                    out_drive:       8'd0,
                                    failed:          1'b0,
                                    last:            1'b1};
                    end
                    UOP_EMIT_DONE_FAIL: begin
                        r_busy  <= 1'b0;
                        r_retry <= '0;
                        r_out   <= '{command:         CMD_DONE,
                                     write_dir:       1'b0,
                                     cyl_sector_word: 16'd0,
                                     head_drive_word: 16'd0,
                                     out_segment:     16'd0,
                                     out_offset:      16'd0,
                                     out_drive:       8'd0,
                                     failed:          1'b1,
                                     last:            1'b1};
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_retry_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_retry} < RETRY_LIM))
        else $error("retry count reached the limit");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= r_total))
        else $error("sector index beyond sector total while busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (w.op == UOP_EMIT_DONE_OK || w.op == UOP_EMIT_DONE_FAIL))
        |=> (!r_busy && r_upc == UPC_FETCH))
        else $error("finished result did not return the sequencer to idle");

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> $stable(r_out))
        else $error("result register overwritten before it was taken");

    a_upc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc <= UPC_EMIT_XFER))
        else $error("program counter outside the microprogram");

endmodule

`default_nettype wire
